### hdl/pending_read_index_tracker_assert.svh
// Assertion macros used by the pending read index tracker datapath.
`ifndef PENDING_READ_INDEX_TRACKER_ASSERT_SVH
`define PENDING_READ_INDEX_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition that holds at every rising clock edge outside reset.
`define PRIT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle, outside reset.
`define PRIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PRIT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define PRIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/prit_pkg.sv
// Package with constants, codes and interface types of the pending read index tracker.
`timescale 1ns / 1ps
package prit_pkg;

  localparam int SLOTS   = 8;
  localparam int MAX_OUT = 8;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int OUTN_W  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

  localparam logic [63:0] ID_PREFIX = 64'h4d43545200000000;
  localparam logic [63:0] SEQ_MASK  = 64'h00000000ffffffff;

  typedef enum logic [1:0] {
    ACT_REQUEST    = 2'd0,
    ACT_READ_STATE = 2'd1,
    ACT_APPLIED    = 2'd2,
    ACT_POLL       = 2'd3
  } prit_action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_FREE   = 2'd1,
    STS_PROTO_ERR = 2'd2,
    STS_NONE      = 2'd3
  } prit_status_t;

  typedef enum logic [2:0] {
    RES_NO_FREE   = 3'd0,
    RES_ALLOC_OK  = 3'd1,
    RES_RS_ERR    = 3'd2,
    RES_RS_OK     = 3'd3,
    RES_APPLIED   = 3'd4,
    RES_POLL_ITEM = 3'd5,
    RES_POLL_NONE = 3'd6
  } prit_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REQ_CHECK,
    ST_REQ_ADV,
    ST_REQ_SCAN,
    ST_RS_SCAN,
    ST_APPLY,
    ST_POLL_SCAN,
    ST_POLL_CHK,
    ST_POLL_EMIT,
    ST_RESULT
  } prit_state_t;

  typedef struct packed {
    logic       latch_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       idx_load_due;
    logic       tries_clr;
    logic       tries_inc;
    logic       seq_adv;
    logic       alloc;
    logic       rs_write;
    logic       applied_write;
    logic       due_clr;
    logic       due_set;
    logic       poll_free;
    logic       n_clr;
    logic       kind_load;
    prit_kind_t kind;
    logic       out_load;
  } prit_cmd_t;

  typedef struct packed {
    logic free_any;
    logic hit;
    logic ready_at;
    logic idx_last;
    logic tries_done;
    logic due_any;
    logic poll_last;
    logic out_space;
  } prit_stat_t;

endpackage

### hdl/prit_ctrl.sv
// Controller state machine of the pending read index tracker.
`timescale 1ns / 1ps
module prit_ctrl
  import prit_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  prit_action_t in_action,
  output logic         in_stall,
  input  prit_stat_t   stat,
  output prit_cmd_t    cmd
);

  prit_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_REQUEST:    state_nxt = ST_REQ_CHECK;
            ACT_READ_STATE: state_nxt = ST_RS_SCAN;
            ACT_APPLIED:    state_nxt = ST_APPLY;
            ACT_POLL:       state_nxt = ST_POLL_SCAN;
            default:        state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_REQ_CHECK: state_nxt = stat.free_any ? ST_REQ_ADV : ST_RESULT;
      ST_REQ_ADV:   state_nxt = ST_REQ_SCAN;
      ST_REQ_SCAN: begin
        if (stat.hit) begin
          state_nxt = stat.tries_done ? ST_RESULT : ST_REQ_ADV;
        end else if (stat.idx_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RS_SCAN: begin
        if (stat.hit || stat.idx_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_APPLY:     state_nxt = ST_RESULT;
      ST_POLL_SCAN: begin
        if (stat.idx_last) begin
          state_nxt = ST_POLL_CHK;
        end
      end
      ST_POLL_CHK:  state_nxt = stat.due_any ? ST_POLL_EMIT : ST_RESULT;
      ST_POLL_EMIT: begin
        if (stat.out_space && stat.poll_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (stat.out_space) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in  = 1'b1;
          cmd.idx_clr   = 1'b1;
          cmd.tries_clr = 1'b1;
          cmd.due_clr   = 1'b1;
        end
      end
      ST_REQ_CHECK: begin
        if (!stat.free_any) begin
          cmd.kind_load = 1'b1;
          cmd.kind      = RES_NO_FREE;
        end
      end
      ST_REQ_ADV: begin
        cmd.seq_adv = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      ST_REQ_SCAN: begin
        if (stat.hit) begin
          if (stat.tries_done) begin
            cmd.kind_load = 1'b1;
            cmd.kind      = RES_NO_FREE;
          end else begin
            cmd.tries_inc = 1'b1;
          end
        end else if (stat.idx_last) begin
          cmd.alloc     = 1'b1;
          cmd.kind_load = 1'b1;
          cmd.kind      = RES_ALLOC_OK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_RS_SCAN: begin
        if (stat.hit) begin
          cmd.kind_load = 1'b1;
          if (stat.ready_at) begin
            cmd.kind = RES_RS_ERR;
          end else begin
            cmd.rs_write = 1'b1;
            cmd.kind     = RES_RS_OK;
          end
        end else if (stat.idx_last) begin
          cmd.kind_load = 1'b1;
          cmd.kind      = RES_RS_ERR;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_APPLY: begin
        cmd.applied_write = 1'b1;
        cmd.kind_load     = 1'b1;
        cmd.kind          = RES_APPLIED;
      end
      ST_POLL_SCAN: begin
        cmd.due_set = 1'b1;
        cmd.idx_inc = !stat.idx_last;
      end
      ST_POLL_CHK: begin
        cmd.kind_load = 1'b1;
        if (stat.due_any) begin
          cmd.idx_load_due = 1'b1;
          cmd.n_clr        = 1'b1;
          cmd.kind         = RES_POLL_ITEM;
        end else begin
          cmd.kind = RES_POLL_NONE;
        end
      end
      ST_POLL_EMIT: begin
        if (stat.out_space) begin
          cmd.out_load     = 1'b1;
          cmd.poll_free    = 1'b1;
          cmd.idx_load_due = 1'b1;
        end
      end
      ST_RESULT: begin
        cmd.out_load = stat.out_space;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/prit_dp.sv
// Datapath of the pending read index tracker: slot store, counters and result register.
`timescale 1ns / 1ps
`include "pending_read_index_tracker_assert.svh"
module prit_dp
  import prit_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  prit_action_t in_action,
  input  logic [63:0]  in_read_context_id,
  input  logic [63:0]  in_read_safe_index,
  input  logic [63:0]  in_new_applied_index,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_status,
  output logic [63:0]  out_ctx_id,
  output logic [63:0]  out_safe_index,
  output logic [63:0]  out_applied_index_now,
  output logic         out_last,
  input  prit_cmd_t    cmd,
  output prit_stat_t   stat
);

  prit_action_t     act_r;
  logic [63:0]      in_id_r;
  logic [63:0]      in_safe_r;
  logic [63:0]      in_applied_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] tries_r;
  logic [OUTN_W-1:0] n_r;
  logic [SLOTS-1:0] due_r;
  prit_kind_t       kind_r;
  logic [SLOTS-1:0] slot_active_r;
  logic [SLOTS-1:0] slot_ready_r;
  logic [31:0]      slot_seq_r [SLOTS];
  logic [63:0]      slot_safe_r [SLOTS];
  logic [63:0]      applied_r;
  logic [31:0]      seq_r;
  logic [CNT_W-1:0] pending_r;
  logic             out_valid_r;
  prit_status_t     out_status_r;
  logic [63:0]      out_id_r;
  logic [63:0]      out_safe_r;
  logic [63:0]      out_applied_r;
  logic             out_last_r;

  logic [31:0]      seq_inc;
  logic [31:0]      seq_nxt;
  logic [31:0]      seq_at;
  logic [63:0]      safe_at;
  logic [31:0]      target_seq;
  logic             prefix_ok;
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic [SLOTS-1:0] idx_onehot;
  logic [SLOTS-1:0] due_rest;
  logic [SLOTS-1:0] due_pick_in;
  logic [IDX_W-1:0] due_idx;
  logic             out_space;
  prit_status_t     res_status;
  logic [63:0]      res_id;
  logic [63:0]      res_safe;
  logic             res_last;

  assign seq_inc    = seq_r + 32'd1;
  assign seq_nxt    = (seq_inc == 32'd0) ? 32'd1 : seq_inc;
  assign seq_at     = slot_seq_r[idx_r];
  assign safe_at    = slot_safe_r[idx_r];
  assign prefix_ok  = ((in_id_r & ~SEQ_MASK) == ID_PREFIX);
  assign target_seq = (act_r == ACT_READ_STATE) ? in_id_r[31:0] : seq_r;
  assign idx_onehot = SLOTS'(1) << idx_r;
  assign due_rest   = due_r & ~idx_onehot;
  assign due_pick_in = cmd.poll_free ? due_rest : due_r;
  assign out_space  = !out_valid_r || !out_stall;

  // Lowest free slot and lowest due slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    due_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_active_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (due_pick_in[i]) begin
        due_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    stat.free_any   = free_any;
    stat.hit        = slot_active_r[idx_r] && (seq_at == target_seq) &&
                      ((act_r != ACT_READ_STATE) || prefix_ok);
    stat.ready_at   = slot_ready_r[idx_r];
    stat.idx_last   = (idx_r == IDX_W'(SLOTS - 1));
    stat.tries_done = (tries_r == pending_r);
    stat.due_any    = |due_r;
    stat.poll_last  = (due_rest == '0) || (n_r == OUTN_W'(MAX_OUT - 1));
    stat.out_space  = out_space;
  end

  always_comb begin
    res_status = STS_OK;
    res_id     = 64'd0;
    res_safe   = 64'd0;
    res_last   = 1'b1;
    unique case (kind_r)
      RES_NO_FREE:   res_status = STS_NO_FREE;
      RES_ALLOC_OK:  res_id = ID_PREFIX | {32'd0, seq_r};
      RES_RS_ERR: begin
        res_status = STS_PROTO_ERR;
        res_id     = in_id_r;
      end
      RES_RS_OK: begin
        res_id   = in_id_r;
        res_safe = in_safe_r;
      end
      RES_APPLIED:   res_status = STS_OK;
      RES_POLL_ITEM: begin
        res_id   = ID_PREFIX | {32'd0, seq_at};
        res_safe = safe_at;
        res_last = stat.poll_last;
      end
      RES_POLL_NONE: res_status = STS_NONE;
      default:       res_status = STS_OK;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_active_r <= '0;
      slot_ready_r  <= '0;
      applied_r     <= 64'd0;
      seq_r         <= 32'd0;
      pending_r     <= '0;
      out_valid_r   <= 1'b0;
      due_r         <= '0;
      act_r         <= ACT_REQUEST;
      kind_r        <= RES_NO_FREE;
      idx_r         <= '0;
      tries_r       <= '0;
      n_r           <= '0;
    end else begin
      if (cmd.latch_in) begin
        act_r <= in_action;
      end
      if (cmd.kind_load) begin
        kind_r <= cmd.kind;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end else if (cmd.idx_load_due) begin
        idx_r <= due_idx;
      end
      if (cmd.tries_clr) begin
        tries_r <= '0;
      end else if (cmd.tries_inc) begin
        tries_r <= tries_r + CNT_W'(1);
      end
      if (cmd.n_clr) begin
        n_r <= '0;
      end else if (cmd.poll_free) begin
        n_r <= n_r + OUTN_W'(1);
      end
      if (cmd.seq_adv) begin
        seq_r <= seq_nxt;
      end
      if (cmd.applied_write) begin
        applied_r <= in_applied_r;
      end
      if (cmd.due_clr) begin
        due_r <= '0;
      end else if (cmd.due_set) begin
        due_r[idx_r] <= slot_active_r[idx_r] && slot_ready_r[idx_r] &&
                        (safe_at <= applied_r);
      end else if (cmd.poll_free) begin
        due_r[idx_r] <= 1'b0;
      end
      if (cmd.alloc) begin
        slot_active_r[free_idx] <= 1'b1;
        slot_ready_r[free_idx]  <= 1'b0;
        pending_r               <= pending_r + CNT_W'(1);
      end else if (cmd.rs_write) begin
        slot_ready_r[idx_r] <= 1'b1;
      end else if (cmd.poll_free) begin
        slot_active_r[idx_r] <= 1'b0;
        slot_ready_r[idx_r]  <= 1'b0;
        if (pending_r != '0) begin
          pending_r <= pending_r - CNT_W'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers and slot store.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_id_r      <= in_read_context_id;
      in_safe_r    <= in_read_safe_index;
      in_applied_r <= in_new_applied_index;
    end
    if (cmd.alloc) begin
      slot_seq_r[free_idx] <= seq_r;
    end
    if (cmd.rs_write) begin
      slot_safe_r[idx_r] <= in_safe_r;
    end
    if (cmd.out_load) begin
      out_status_r  <= res_status;
      out_id_r      <= res_id;
      out_safe_r    <= res_safe;
      out_applied_r <= applied_r;
      out_last_r    <= res_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_ctx_id            = out_id_r;
  assign out_safe_index        = out_safe_r;
  assign out_applied_index_now = out_applied_r;
  assign out_last              = out_last_r;

  `PRIT_ASSERT_ALWAYS(a_pending_count, clk, rst_n, int'(pending_r) == $countones(slot_active_r), "pending count differs from active slots")
  `PRIT_ASSERT_ALWAYS(a_ready_active, clk, rst_n, (slot_ready_r & ~slot_active_r) == '0, "ready slot not active")
  `PRIT_ASSERT_IMPLY(a_alloc_free, clk, rst_n, cmd.alloc, free_any && !slot_active_r[free_idx], "allocation into busy slot")
  `PRIT_ASSERT_IMPLY(a_rs_write, clk, rst_n, cmd.rs_write, slot_active_r[idx_r] && !slot_ready_r[idx_r], "read state on bad slot")
  `PRIT_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || !out_stall, "stalled result overwritten")

endmodule

### hdl/pending_read_index_tracker.sv
// Top level of the pending read index tracker: controller and datapath.
// Poll: one safe-index compare per slot before the first completion, then one a cycle while the result side takes them.
// Throughput: one request at a time; the slot scan, one slot per cycle, sets the rate.
// Reset: synchronous active-low rst_n frees every slot and clears the counters.
`timescale 1ns / 1ps
module pending_read_index_tracker
  import prit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [63:0] in_read_context_id,
  input  logic [63:0] in_read_safe_index,
  input  logic [63:0] in_new_applied_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_ctx_id,
  output logic [63:0] out_safe_index,
  output logic [63:0] out_applied_index_now,
  output logic        out_last
);

  // The controller sequences each request through per-slot scan steps; the
  // datapath holds the slot store, the id sequence counter and the result
  // register. The two talk only through the command and status structs.
  prit_cmd_t    cmd;
  prit_stat_t   stat;
  prit_action_t action;

  // The action field carries the whole two-bit code space.
  assign action = prit_action_t'(in_action);

  // A request is taken only while the controller is idle. A finished
  // result can still sit in the output register waiting on out_stall while
  // the next request is accepted and processed up to its own result.
  prit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Poll completions leave one per cycle in slot order while the result
  // side takes them; the last one carries out_last.
  prit_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_action             (action),
    .in_read_context_id    (in_read_context_id),
    .in_read_safe_index    (in_read_safe_index),
    .in_new_applied_index  (in_new_applied_index),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_ctx_id            (out_ctx_id),
    .out_safe_index        (out_safe_index),
    .out_applied_index_now (out_applied_index_now),
    .out_last              (out_last),
    .cmd                   (cmd),
    .stat                  (stat)
  );

endmodule

### tb/sv/pending_read_index_tracker_checker.sv
// Checker for the pending read index tracker: predicts every result and compares it.
`timescale 1ns / 1ps
module pending_read_index_tracker_checker
  import prit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [63:0] in_read_context_id,
  input  logic [63:0] in_read_safe_index,
  input  logic [63:0] in_new_applied_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [63:0] out_ctx_id,
  input  logic [63:0] out_safe_index,
  input  logic [63:0] out_applied_index_now,
  input  logic        out_last,
  output int          mismatch_count,
  output int          results_awaited
);

  typedef struct packed {
    prit_status_t status;
    logic [63:0]  ctx_id;
    logic [63:0]  safe_idx;
    logic [63:0]  applied_now;
    logic         last;
  } read_result_t;

  // Shadow copy of the slot table and counters.
  logic        slot_busy [SLOTS];
  logic        slot_done [SLOTS];
  logic [31:0] slot_seq  [SLOTS];
  logic [63:0] slot_safe [SLOTS];
  logic [63:0] applied_now;
  logic [31:0] seq_ctr;
  int          busy_count;

  read_result_t awaited_results[$];
  int           bad_results;
  int           awaited_count;
  int           result_num;

  assign mismatch_count  = bad_results;
  assign results_awaited = awaited_count;

  function automatic void await_result(prit_status_t status, logic [63:0] id,
                                       logic [63:0] safe, logic last);
    read_result_t r;
    r.status      = status;
    r.ctx_id      = id;
    r.safe_idx    = safe;
    r.applied_now = applied_now;
    r.last        = last;
    awaited_results.push_back(r);
  endfunction

  // Slot holding an id, or -1 when the prefix is wrong or no active slot matches.
  function automatic int slot_of(logic [63:0] id);
    if ((id & ~SEQ_MASK) != ID_PREFIX) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_busy[i] && slot_seq[i] == id[31:0]) return i;
    return -1;
  endfunction

  function automatic void predict_read_results(prit_action_t act, logic [63:0] rid,
                                               logic [63:0] rsafe, logic [63:0] napp);
    int          free_slot;
    int          hit;
    int          due;
    int          k;
    logic [63:0] id;
    bit          placed;
    free_slot = -1;
    placed    = 1'b0;
    id        = '0;
    case (act)
      ACT_REQUEST: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!slot_busy[i]) free_slot = i;
        // The sequence skips zero and retries while the id is held by a slot.
        if (free_slot >= 0) begin
          for (int t = 0; t <= busy_count && !placed; t++) begin
            seq_ctr = seq_ctr + 32'd1;
            if (seq_ctr == 32'd0) seq_ctr = 32'd1;
            id = ID_PREFIX | {32'd0, seq_ctr};
            if (slot_of(id) < 0) begin
              slot_busy[free_slot] = 1'b1;
              slot_done[free_slot] = 1'b0;
              slot_seq[free_slot]  = seq_ctr;
              slot_safe[free_slot] = '0;
              busy_count++;
              placed = 1'b1;
            end
          end
        end
        if (placed) await_result(STS_OK, id, '0, 1'b1);
        else await_result(STS_NO_FREE, '0, '0, 1'b1);
      end
      ACT_READ_STATE: begin
        hit = slot_of(rid);
        if (hit < 0 || slot_done[hit]) begin
          await_result(STS_PROTO_ERR, rid, '0, 1'b1);
        end else begin
          slot_safe[hit] = rsafe;
          slot_done[hit] = 1'b1;
          await_result(STS_OK, rid, rsafe, 1'b1);
        end
      end
      ACT_APPLIED: begin
        applied_now = napp;
        await_result(STS_OK, '0, '0, 1'b1);
      end
      default: begin
        due = 0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_busy[i] && slot_done[i] && slot_safe[i] <= applied_now) due++;
        if (due > MAX_OUT) due = MAX_OUT;
        if (due == 0) begin
          await_result(STS_NONE, '0, '0, 1'b1);
        end else begin
          k = 0;
          for (int i = 0; i < SLOTS && k < due; i++) begin
            if (slot_busy[i] && slot_done[i] && slot_safe[i] <= applied_now) begin
              await_result(STS_OK, ID_PREFIX | {32'd0, slot_seq[i]}, slot_safe[i],
                           k == due - 1);
              slot_busy[i] = 1'b0;
              slot_done[i] = 1'b0;
              if (busy_count > 0) busy_count--;
              k++;
            end
          end
        end
      end
    endcase
  endfunction

  initial begin
    bad_results   = 0;
    awaited_count = 0;
    result_num    = 0;
  end

  always @(posedge clk) begin
    read_result_t want;
    read_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i] = 1'b0;
        slot_done[i] = 1'b0;
        slot_seq[i]  = '0;
        slot_safe[i] = '0;
      end
      applied_now = '0;
      seq_ctr     = '0;
      busy_count  = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_read_results(prit_action_t'(in_action), in_read_context_id,
                             in_read_safe_index, in_new_applied_index);
      if (out_valid && !out_stall) begin
        got.status      = prit_status_t'(out_status);
        got.ctx_id      = out_ctx_id;
        got.safe_idx    = out_safe_index;
        got.applied_now = out_applied_index_now;
        got.last        = out_last;
        if (awaited_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("ERROR: result %0d arrived with none awaited:", result_num,
                     " status %0d id %h safe %h applied %h last %0b",
                     got.status, got.ctx_id, got.safe_idx, got.applied_now, got.last);
        end else begin
          want = awaited_results.pop_front();
          if (got != want) begin
            bad_results++;
            if (bad_results <= 10)
              $display("ERROR: result %0d expected status %0d id %h safe %h",
                       result_num, want.status, want.ctx_id, want.safe_idx,
                       " applied %h last %0b, got status %0d id %h", want.applied_now,
                       want.last, got.status, got.ctx_id,
                       " safe %h applied %h last %0b", got.safe_idx, got.applied_now,
                       got.last);
          end
        end
        result_num++;
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

### tb/sv/pending_read_index_tracker_tb.sv
// Testbench top for the pending read index tracker: stimulus, receiver, watchdog and verdict.
`timescale 1ns / 1ps
module pending_read_index_tracker_tb;
  import prit_pkg::*;

  // Cycles without any accepted request or result before the run is abandoned.
  // The long receiver hold-off below is far shorter, so this leaves ample margin.
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [63:0] in_read_context_id;
  logic [63:0] in_read_safe_index;
  logic [63:0] in_new_applied_index;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [63:0] out_ctx_id;
  logic [63:0] out_safe_index;
  logic [63:0] out_applied_index_now;
  logic        out_last;

  int mismatch_count;
  int results_awaited;

  // Sender pacing: in a calm stretch every request is offered back to back.
  bit          calm_in;
  // Last applied index sent, so that safe indexes land near it and polls complete.
  logic [63:0] applied_sent;
  // Ring of ids seen in successful results, used to build matching read states.
  logic [63:0] known_ids [16];
  logic [3:0]  ring_wr;
  int          known_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pending_read_index_tracker DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_read_context_id   (in_read_context_id),
    .in_read_safe_index   (in_read_safe_index),
    .in_new_applied_index (in_new_applied_index),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_ctx_id           (out_ctx_id),
    .out_safe_index       (out_safe_index),
    .out_applied_index_now(out_applied_index_now),
    .out_last             (out_last)
  );

  pending_read_index_tracker_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_read_context_id   (in_read_context_id),
    .in_read_safe_index   (in_read_safe_index),
    .in_new_applied_index (in_new_applied_index),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_ctx_id           (out_ctx_id),
    .out_safe_index       (out_safe_index),
    .out_applied_index_now(out_applied_index_now),
    .out_last             (out_last),
    .mismatch_count       (mismatch_count),
    .results_awaited      (results_awaited)
  );

  // Learn live context ids from the result stream. Ids of completed reads are
  // collected too; they later make useful stale read states.
  initial begin
    ring_wr = '0;
    known_n = 0;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall && prit_status_t'(out_status) == STS_OK &&
        out_ctx_id[63:32] == ID_PREFIX[63:32]) begin
      known_ids[ring_wr] <= out_ctx_id;
      ring_wr <= ring_wr + 4'd1;
      if (known_n < 16) known_n <= known_n + 1;
    end
  end

  // Offer one request: idle for a drawn number of cycles, then hold the payload
  // steady until the block takes it. Every call starts and ends on a falling edge.
  task automatic offer(input prit_action_t act, input logic [63:0] rid,
                       input logic [63:0] rsafe, input logic [63:0] napp);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action            <= act;
    in_read_context_id   <= rid;
    in_read_safe_index   <= rsafe;
    in_new_applied_index <= napp;
    in_valid             <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Receiver: draws a stall length per result. Once, after HOLD_AT results, it
  // holds off for a long stretch so that the block backs up and stalls its input.
  initial begin
    int  wait_n;
    int  taken;
    bit  calm_out;
    taken    = 0;
    calm_out = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (taken % 40 == 0) calm_out = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) wait_n = HOLD_CYCLES;
      else if (calm_out) wait_n = 0;
      else wait_n = $urandom_range(0, 12);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  // Watchdog: any stretch without traffic on either channel that exceeds the
  // limit means the block has hung.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int           pick;
    int           sel;
    prit_action_t act;
    logic [63:0]  rid;
    logic [63:0]  rsafe;
    logic [63:0]  napp;
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_action            <= ACT_POLL;
    in_read_context_id   <= '0;
    in_read_safe_index   <= '0;
    in_new_applied_index <= '0;
    calm_in      = 1'b0;
    applied_sent = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. After reset the sequence starts at one, so the first eight
    // allocations get the ids with sequences one to eight.
    // A poll with nothing pending, and a read state for an id never handed out.
    offer(ACT_POLL, '0, '0, '0);
    offer(ACT_READ_STATE, ID_PREFIX | 64'd1, 64'd9, '0);
    offer(ACT_APPLIED, {$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
    // Fill every slot, then one more request finds no free slot.
    repeat (SLOTS + 1) offer(ACT_REQUEST, {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
    // Mark every slot ready, with safe indexes at both extremes.
    for (int k = 1; k <= SLOTS; k++) begin
      if (k == 1) rsafe = 64'd5;
      else if (k == 2) rsafe = '1;
      else if (k == 3) rsafe = '0;
      else rsafe = {$urandom, $urandom};
      offer(ACT_READ_STATE, ID_PREFIX | 64'(k), rsafe, {$urandom, $urandom});
    end
    // A read state for a slot that is already ready, and one with a bad prefix.
    offer(ACT_READ_STATE, ID_PREFIX | 64'd1, 64'd3, '0);
    offer(ACT_READ_STATE, 64'h4d43545300000004, 64'd3, '0);
    // The largest applied index makes all eight due in a single poll; the
    // poll after that finds nothing left.
    applied_sent = '1;
    offer(ACT_APPLIED, '0, '0, applied_sent);
    offer(ACT_POLL, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    offer(ACT_POLL, '0, '0, '0);

    // Random part: mostly well-formed traffic, with stale ids, wrong prefixes
    // and arbitrary values mixed in. Unused fields carry random bits.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 99);
      rid   = {$urandom, $urandom};
      rsafe = {$urandom, $urandom};
      napp  = {$urandom, $urandom};
      if (pick < 30) begin
        act = ACT_REQUEST;
      end else if (pick < 65) begin
        act = ACT_READ_STATE;
        sel = $urandom_range(0, 99);
        if (sel < 75 && known_n > 0) rid = known_ids[$urandom_range(0, known_n - 1)];
        else if (sel < 85) rid = ID_PREFIX | {32'd0, $urandom};
        if (sel >= 90 && known_n > 0)
          rid = known_ids[$urandom_range(0, known_n - 1)] ^
                (64'd1 << $urandom_range(32, 63));
        // Safe indexes mostly close to the applied index, some well ahead of it.
        sel = $urandom_range(0, 99);
        if (sel < 60) rsafe = applied_sent - 64'd8 + 64'($urandom_range(0, 24));
        else if (sel < 85) rsafe = applied_sent + 64'($urandom_range(20, 200));
      end else if (pick < 77) begin
        act = ACT_APPLIED;
        sel = $urandom_range(0, 99);
        if (sel < 70) napp = applied_sent + 64'($urandom_range(0, 30));
        else if (sel < 80) napp = '0;
        else if (sel < 90) napp = '1;
        applied_sent = napp;
      end else begin
        act = ACT_POLL;
      end
      offer(act, rid, rsafe, napp);
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then give stray results time
    // to show up before the verdict.
    while (results_awaited != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && results_awaited == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
